[hw/rtl/smi_pkg.sv]
// Shared types and constants for the small matrix inverse block.
// No dependencies; used by smi_divider and small_matrix_inverse.
package smi_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 3;

    // Matrix size after reset
    localparam logic [CFG_W-1:0] SIZE_RESET = 3'd4;

    // Saturation limits of the Q format
    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SUB_INIT,
        ST_TUP,
        ST_FETCH,
        ST_MUL,
        ST_ACC,
        ST_ADV,
        ST_DET_DONE,
        ST_COF_DONE,
        ST_DIV,
        ST_OUT
    } smi_state_t;

endpackage

[hw/rtl/smi_divider.sv]
// Restoring divider, one quotient bit per cycle, with a 32-bit quotient
// and a flag for any quotient bit above it. Depends on smi_pkg.
module smi_divider #(
    parameter int NUM_W = 216,
    parameter int DEN_W = 168
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [NUM_W-1:0]           num,
    input  logic [DEN_W-1:0]           den,   // held stable while running
    output logic                       done,
    output logic [smi_pkg::DATA_W-1:0] quo,
    output logic                       big
);
    import smi_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DATA_W-1:0] q_reg;
    logic             big_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    // one trial subtraction per cycle
    always_comb begin
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, den};
        ge      = (rem_sh >= {1'b0, den});
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && cnt_reg == CNT_W'(NUM_W - 1)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            num_reg <= num;
            rem_reg <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
        end else if (run_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            q_reg   <= {q_reg[DATA_W-2:0], ge};
            big_reg <= big_reg | q_reg[DATA_W-1];
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign big  = big_reg;

endmodule

[hw/rtl/small_matrix_inverse.sv]
// Top level: matrix inverse through the adjugate, Leibniz determinants.
// Depends on smi_pkg and smi_divider.
//
//  channel | dir | fields (lsb first)             | accepted when
//  s_      | in  | tdata: element_value          | s_tvalid & s_tready
//  m_      | out | tdata: result_value, tuser: singular, tlast: last
//                                                  | m_tvalid & m_tready
//  cfg_    | in  | data: matrix_size             | cfg_valid & cfg_ready
//
// Elements load at one per cycle. After the last one the block is busy:
// every sub-determinant walks all k^k index tuples with a shared 32x32 multiplier: each
// permutation fetches its k elements and multiplies them in limb by limb; others are skipped.
// Each result of a non-singular matrix then takes a cofactor plus a division by the determinant.
// s_tready is low from the last element until the last result goes, and while a size write
// is offered; size writes are taken only while loading.
// Reset (synchronous, aresetn low) sets size 4 and empties the partial load.
module small_matrix_inverse #(
    parameter int MAX_SIZE  = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic signed [smi_pkg::DATA_W-1:0] s_tdata,   // element_value
    input  logic                              s_tvalid,
    output logic                              s_tready,
    output logic signed [smi_pkg::DATA_W-1:0] m_tdata,   // result_value
    output logic                              m_tuser,   // singular
    output logic                              m_tlast,   // last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [smi_pkg::CFG_W-1:0]         cfg_data   // matrix_size
);
    import smi_pkg::*;

    localparam int LIMBS = MAX_SIZE;
    localparam int PW    = DATA_W * LIMBS;
    localparam int AW    = PW + 8;
    localparam int NW    = AW + 2 * FRAC_BITS;
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AD    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int NB    = $clog2(MAX_SIZE + 1);
    localparam int DB    = $clog2(MAX_SIZE);
    localparam int LB    = $clog2(LIMBS);

    smi_state_t state_reg, state_next;

    logic [CFG_W-1:0]  size_reg;
    logic [CW-1:0]     load_cnt_reg;
    logic [DATA_W-1:0] store_reg [DEPTH];

    // sub-determinant engine
    logic [NB-1:0]     k_reg;
    logic [NB-1:0]     ex_row_reg;
    logic [NB-1:0]     ex_col_reg;
    logic [NB-1:0]     d_reg;
    logic [DB-1:0]     tup_reg [MAX_SIZE];
    logic [PW-1:0]     prod_reg;
    logic [DATA_W-1:0] mag_reg;
    logic [DATA_W-1:0] carry_reg;
    logic [LB-1:0]     limb_reg;
    logic              sgn_reg;
    logic [AW-1:0]     acc_reg;
    logic              det_pass_reg;

    logic [AW-1:0]     det_mag_reg;
    logic              det_neg_reg;
    logic [DB-1:0]     r_reg;
    logic [DB-1:0]     c_reg;
    logic              res_neg_reg;
    logic [DATA_W-1:0] res_reg;
    logic              sing_reg;
    logic              last_reg;

    // derived values
    logic [NB-1:0]     n_eff;
    logic [2*NB-1:0]   nn;
    logic [CW-1:0]     cnt_inc;
    logic              load_last;
    logic              perm_ok;
    logic              parity;
    logic [DB-1:0]     tup_inc [MAX_SIZE];
    logic              tup_wrap;
    logic [DB-1:0]     dig;
    logic [NB-1:0]     row_idx;
    logic [NB-1:0]     col_idx;
    logic [2*NB-1:0]   lin;
    logic [DATA_W-1:0] rd_data;
    logic [63:0]       mprod;
    logic [AW-1:0]     prod_ext;
    logic [AW-1:0]     acc_mag;
    logic              res_last;
    logic [DB-1:0]     r_adv;
    logic [DB-1:0]     c_adv;
    logic [DATA_W-1:0] sat_val;
    logic              load_acc;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    logic              div_big;

    // effective size and element count
    always_comb begin
        if (size_reg == '0) begin
            n_eff = NB'(1);
        end else if (int'(size_reg) > MAX_SIZE) begin
            n_eff = NB'(MAX_SIZE);
        end else begin
            n_eff = NB'(size_reg);
        end
        nn        = (2*NB)'(n_eff) * (2*NB)'(n_eff);
        cnt_inc   = load_cnt_reg + CW'(1);
        load_last = ((2*NB)'(cnt_inc) == nn);
    end

    // permutation check and parity over the current tuple
    always_comb begin
        perm_ok = 1'b1;
        parity  = 1'b0;
        for (int i = 0; i < MAX_SIZE; i++) begin
            for (int j = 0; j < MAX_SIZE; j++) begin
                if (i < j && j < int'(k_reg)) begin
                    if (tup_reg[i] == tup_reg[j]) perm_ok = 1'b0;
                    if (tup_reg[i] > tup_reg[j]) parity = ~parity;
                end
            end
        end
    end

    // base-k tuple increment
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int i = 0; i < MAX_SIZE; i++) begin
            tup_inc[i] = tup_reg[i];
            if (i < int'(k_reg) && carry) begin
                if (tup_reg[i] == DB'(k_reg - NB'(1))) begin
                    tup_inc[i] = '0;
                end else begin
                    tup_inc[i] = tup_reg[i] + DB'(1);
                    carry      = 1'b0;
                end
            end
        end
        tup_wrap = carry;
    end

    // element address for the current depth, skipping excluded row/col
    always_comb begin
        dig     = tup_reg[d_reg[DB-1:0]];
        row_idx = d_reg + NB'(d_reg >= ex_row_reg);
        col_idx = NB'(dig) + NB'(NB'(dig) >= ex_col_reg);
        lin     = (2*NB)'(row_idx) * (2*NB)'(n_eff) + (2*NB)'(col_idx);
        rd_data = store_reg[lin[AD-1:0]];
    end

    // shared multiplier, one limb per cycle
    always_comb begin
        mprod    = {32'b0, prod_reg[DATA_W-1:0]} * {32'b0, mag_reg} + {32'b0, carry_reg};
        prod_ext = AW'(prod_reg);
        acc_mag  = acc_reg[AW-1] ? (~acc_reg + AW'(1)) : acc_reg;
    end

    // result position bookkeeping
    always_comb begin
        res_last = (NB'(r_reg) == n_eff - NB'(1)) && (NB'(c_reg) == n_eff - NB'(1));
        if (NB'(c_reg) == n_eff - NB'(1)) begin
            c_adv = '0;
            r_adv = r_reg + DB'(1);
        end else begin
            c_adv = c_reg + DB'(1);
            r_adv = r_reg;
        end
    end

    // quotient saturation
    always_comb begin
        if (res_neg_reg) begin
            if (div_big || div_quo > SAT_NEG) sat_val = SAT_NEG;
            else sat_val = ~div_quo + DATA_W'(1);
        end else begin
            if (div_big || div_quo[DATA_W-1]) sat_val = SAT_POS;
            else sat_val = div_quo;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (load_acc && load_last) state_next = ST_SUB_INIT;
            end
            ST_SUB_INIT: state_next = ST_TUP;
            ST_TUP: begin
                if (!perm_ok) state_next = ST_ADV;
                else if (k_reg == '0) state_next = ST_ACC;
                else state_next = ST_FETCH;
            end
            ST_FETCH: state_next = ST_MUL;
            ST_MUL: begin
                if (limb_reg == LB'(LIMBS - 1)) begin
                    state_next = (d_reg + NB'(1) == k_reg) ? ST_ACC : ST_FETCH;
                end
            end
            ST_ACC: state_next = ST_ADV;
            ST_ADV: begin
                if (!tup_wrap) state_next = ST_TUP;
                else if (det_pass_reg) state_next = ST_DET_DONE;
                else state_next = ST_COF_DONE;
            end
            ST_DET_DONE: state_next = (acc_reg == '0) ? ST_OUT : ST_SUB_INIT;
            ST_COF_DONE: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) state_next = (last_reg) ? ST_LOAD : ST_SUB_INIT;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // handshake outputs; a size write wins over an element in the same cycle
    always_comb begin
        s_tready  = (state_reg == ST_LOAD) && !cfg_valid;
        m_tvalid  = (state_reg == ST_OUT);
        div_start = (state_reg == ST_COF_DONE);
        cfg_ready = (state_reg == ST_LOAD);
        load_acc  = s_tvalid && s_tready;
        m_tdata   = res_reg;
        m_tuser   = sing_reg;
        m_tlast   = last_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            size_reg     <= SIZE_RESET;
            load_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                size_reg     <= cfg_data;
                load_cnt_reg <= '0;
            end else if (load_acc) begin
                load_cnt_reg <= load_last ? '0 : cnt_inc;
            end
        end
    end

    // element store
    always_ff @(posedge aclk) begin
        if (load_acc) store_reg[load_cnt_reg[AD-1:0]] <= s_tdata;
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_LOAD: begin
                if (load_acc && load_last) begin
                    det_pass_reg <= 1'b1;
                    k_reg        <= n_eff;
                    ex_row_reg   <= n_eff;
                    ex_col_reg   <= n_eff;
                end
            end
            ST_SUB_INIT: begin
                acc_reg <= '0;
                for (int i = 0; i < MAX_SIZE; i++) tup_reg[i] <= '0;
            end
            ST_TUP: begin
                prod_reg <= PW'(1);
                sgn_reg  <= parity;
                d_reg    <= '0;
            end
            ST_FETCH: begin
                mag_reg   <= rd_data[DATA_W-1] ? (~rd_data + DATA_W'(1)) : rd_data;
                sgn_reg   <= sgn_reg ^ rd_data[DATA_W-1];
                carry_reg <= '0;
                limb_reg  <= '0;
            end
            ST_MUL: begin
                prod_reg  <= {mprod[DATA_W-1:0], prod_reg[PW-1:DATA_W]};
                carry_reg <= mprod[63:32];
                limb_reg  <= limb_reg + LB'(1);
                if (limb_reg == LB'(LIMBS - 1)) d_reg <= d_reg + NB'(1);
            end
            ST_ACC: begin
                acc_reg <= sgn_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
            end
            ST_ADV: begin
                for (int i = 0; i < MAX_SIZE; i++) tup_reg[i] <= tup_inc[i];
            end
            ST_DET_DONE: begin
                det_mag_reg  <= acc_mag;
                det_neg_reg  <= acc_reg[AW-1];
                det_pass_reg <= 1'b0;
                k_reg        <= k_reg - NB'(1);
                ex_row_reg   <= '0;
                ex_col_reg   <= '0;
                r_reg        <= '0;
                c_reg        <= '0;
                res_reg      <= '0;
                sing_reg     <= 1'b1;
                last_reg     <= 1'b1;
            end
            ST_COF_DONE: begin
                res_neg_reg <= acc_reg[AW-1] ^ r_reg[0] ^ c_reg[0] ^ det_neg_reg;
            end
            ST_DIV: begin
                if (div_done) begin
                    res_reg  <= sat_val;
                    sing_reg <= 1'b0;
                    last_reg <= res_last;
                end
            end
            ST_OUT: begin
                if (m_tready && !last_reg) begin
                    r_reg      <= r_adv;
                    c_reg      <= c_adv;
                    ex_row_reg <= NB'(c_adv);
                    ex_col_reg <= NB'(r_adv);
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // cofactor / determinant division
    smi_divider #(
        .NUM_W (NW),
        .DEN_W (AW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({acc_mag, {(2*FRAC_BITS){1'b0}}}),
        .den     (det_mag_reg),
        .done    (div_done),
        .quo     (div_quo),
        .big     (div_big)
    );

`ifndef ASSERT_OFF
    // input and output sides are never open together
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    // a singular report is a lone zero result
    a_singular: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("singular result not zero or not last");

    // the divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside the divide wait");
`endif

endmodule

[sim/small_matrix_inverse_test.sv]
// Self-checking testbench for small_matrix_inverse: streams matrices in and
// checks every inverse element against an exact integer adjugate predictor.
// Depends on smi_pkg and the small_matrix_inverse RTL.
`timescale 1ns / 100ps

// Holds the loaded matrix, the size setting and the queue of predicted results
class inverse_scoreboard;
    typedef struct {
        logic signed [smi_pkg::DATA_W-1:0] value;
        logic                              singular;
        logic                              last;
    } inverse_elem_t;

    typedef logic signed [255:0] exact_t;

    logic [smi_pkg::DATA_W-1:0] elements[16];
    int                         load_count;
    logic [smi_pkg::CFG_W-1:0]  size_reg;
    inverse_elem_t              expected_q[$];
    int                         errors;
    int                         results_seen;
    int                         singular_seen;
    int                         saturated_seen;

    function new();
        load_count = 0;
        size_reg   = smi_pkg::SIZE_RESET;
        errors     = 0;
    endfunction

    function int eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > 4) return 4;
        return size_reg;
    endfunction

    // A size write drops any partial matrix
    function void write_size(logic [smi_pkg::CFG_W-1:0] v);
        size_reg   = v;
        load_count = 0;
    endfunction

    // Exact determinant of the rows/columns picked by the masks (Laplace on first row)
    function exact_t sub_det(int rmask, int cmask, int n);
        exact_t acc;
        exact_t term;
        exact_t elem;
        int     r;
        int     pos;
        if (rmask == 0) return 1;
        acc = 0;
        r   = 0;
        while (!rmask[r]) r++;
        pos = 0;
        for (int c = 0; c < n; c++) begin
            if (cmask[c]) begin
                elem = $signed(elements[r*n + c]);
                term = elem * sub_det(rmask & ~(1 << r), cmask & ~(1 << c), n);
                acc  = pos[0] ? acc - term : acc + term;
                pos++;
            end
        end
        return acc;
    endfunction

    // Quotient truncated toward zero, then clamped to 32 bits
    function logic [31:0] sat_div(exact_t num, exact_t den);
        exact_t q;
        logic   neg;
        neg = num[255] ^ den[255];
        q   = (num[255] ? -num : num) / (den[255] ? -den : den);
        if (neg) begin
            if (q > 256'h8000_0000) begin saturated_seen++; return smi_pkg::SAT_NEG; end
            return -q[31:0];
        end
        if (q > 256'h7FFF_FFFF) begin saturated_seen++; return smi_pkg::SAT_POS; end
        return q[31:0];
    endfunction

    // Note an accepted element; on the last one predict the whole inverse
    function void note_element(logic [31:0] v);
        int            n;
        int            full;
        exact_t        det;
        exact_t        cof;
        inverse_elem_t e;
        n    = eff_size();
        full = (1 << n) - 1;
        if (load_count >= n*n) load_count = 0;
        elements[load_count] = v;
        load_count++;
        if (load_count < n*n) return;
        load_count = 0;
        det = sub_det(full, full, n);
        if (det == 0) begin
            e.value = 0; e.singular = 1; e.last = 1;
            expected_q.push_back(e);
            singular_seen++;
            return;
        end
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                cof = sub_det(full & ~(1 << c), full & ~(1 << r), n);
                if ((r + c) % 2) cof = -cof;
                e.value    = sat_div(cof <<< 32, det);
                e.singular = 0;
                e.last     = (r == n-1) && (c == n-1);
                expected_q.push_back(e);
            end
        end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(logic [31:0] v, logic sing, logic lst);
        inverse_elem_t e;
        results_seen++;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result value=%h singular=%b last=%b",
                     $time, v, sing, lst);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (v !== e.value) begin
            $display("%0t: value mismatch exp=%h act=%h", $time, e.value, v);
            errors++;
        end
        if (sing !== e.singular) begin
            $display("%0t: singular mismatch exp=%b act=%b", $time, e.singular, sing);
            errors++;
        end
        if (lst !== e.last) begin
            $display("%0t: last mismatch exp=%b act=%b", $time, e.last, lst);
            errors++;
        end
    endfunction
endclass

module small_matrix_inverse_test;
    import smi_pkg::*;

    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  HOLD_CYCLES = 4000;
    localparam int  SETTLE      = 40;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic                     aclk      = 0;
    logic                     aresetn   = 0;
    logic signed [DATA_W-1:0] s_tdata   = 0;
    logic                     s_tvalid  = 0;
    logic                     s_tready;
    logic signed [DATA_W-1:0] m_tdata;
    logic                     m_tuser;
    logic                     m_tlast;
    logic                     m_tvalid;
    logic                     m_tready  = 0;
    logic                     cfg_valid = 0;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_data  = 0;

    inverse_scoreboard sb = new();
    int  cycles     = 0;
    int  burst_left = 0;
    int  items_sent = 0;
    int  matrices   = 0;
    bit  hold_req   = 0;
    bit  hold_done  = 0;

    small_matrix_inverse u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.expected_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: check, then pick next ready from the stall pattern
    int stall_left = 0;
    int hold_left  = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_req && !hold_done && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
            m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 0;
        end else begin
            // long free-running stretches, sometimes short or medium stalls
            case ($urandom_range(0, 15))
                0:       stall_left = $urandom_range(1, 3);
                1:       stall_left = $urandom_range(5, 30);
                default: stall_left = 0;
            endcase
            m_tready <= (stall_left == 0) &&
                        ((cycles / 500) % 3 == 0 || $urandom_range(0, 5) != 0);
        end
    end

    // One element request, bursts separated by random gaps
    task automatic send_element(logic [31:0] v);
        if (burst_left == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 14);
        end
        s_tdata  <= v;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        sb.note_element(v);
        burst_left--;
        items_sent++;
    endtask

    // Wait until the block is drained before touching the size register
    task automatic wait_drained();
        s_tvalid <= 0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_size(logic [CFG_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.write_size(v);
    endtask

    task automatic resize(logic [CFG_W-1:0] v);
        wait_drained();
        write_size(v);
    endtask

    // Element value classes: small Q values, full range, exact 1.0 multiples
    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return ($urandom_range(0, 8) - 4) * ONE;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    // Full matrix of the current size; kind 1 forces a repeated row (singular)
    task automatic send_matrix(int kind);
        int          n;
        logic [31:0] row0[4];
        logic [31:0] v;
        n = sb.eff_size();
        for (int i = 0; i < n*n; i++) begin
            v = rand_elem();
            if (i < n) row0[i] = v;
            if (kind == 1 && n > 1 && i >= n*n - n) v = row0[i % n];
            send_element(v);
        end
        matrices++;
    endtask

    task automatic send_diag(int n, logic [31:0] d, logic [31:0] off);
        for (int i = 0; i < n*n; i++)
            send_element((i % (n+1) == 0) ? d : off);
        matrices++;
    endtask

    initial begin
        int n;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset size 4, identity, with the long receiver hold-off
        hold_req = 1;
        send_diag(4, ONE, 0);
        hold_req = 0;
        // all-zero 4x4 is singular
        send_diag(4, 0, 0);

        // 1x1 extremes: 1.0, most negative, tiny (saturates), zero (singular)
        resize(CFG_W'(1));
        send_diag(1, ONE, 0);
        send_diag(1, 32'h8000_0000, 0);
        send_diag(1, 32'h0000_0001, 0);
        send_diag(1, 32'hFFFF_FFFF, 0);
        send_diag(1, 32'h7FFF_FFFF, 0);
        send_diag(1, 0, 0);

        // size 0 behaves as 1
        resize(CFG_W'(0));
        send_diag(1, 32'h0002_0000, 0);

        // 2x2 with extreme entries
        resize(CFG_W'(2));
        send_diag(2, 32'h7FFF_FFFF, 32'h8000_0000);

        // partial load then a size write drops it
        send_element(32'h1234_5678);
        resize(CFG_W'(3));
        send_diag(3, 32'h0002_0000, 32'h0000_8000);

        // sizes above the maximum behave as 4
        resize(CFG_W'(7));
        send_matrix(0);

        // Random matrices, mostly small sizes; a few singular or broken loads
        while (items_sent < 180) begin
            case ($urandom_range(0, 11))
                0:       n = 1;
                1, 2:    n = 4;
                3:       n = $urandom_range(5, 7);
                4:       n = 0;
                5, 6, 7: n = 3;
                default: n = 2;
            endcase
            if (n != sb.size_reg) resize(CFG_W'(n));
            if ($urandom_range(0, 9) == 0) begin
                send_element(rand_elem());
                resize(CFG_W'(n));
            end
            send_matrix($urandom_range(0, 5) == 0 ? 1 : 0);
        end

        wait_drained();
        $display("run covered %0d elements in %0d matrices, %0d results checked",
                 items_sent, matrices, sb.results_seen);
        $display("sizes 0..7 programmed, %0d singular and %0d saturated predictions",
                 sb.singular_seen, sb.saturated_seen);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

[sim.f]
hw/rtl/smi_pkg.sv
hw/rtl/smi_divider.sv
hw/rtl/small_matrix_inverse.sv
sim/small_matrix_inverse_test.sv
